@@ design/brl_pkg.sv @@
// Shared types and constants for the Bresenham line rasterizer.
// No dependencies; every other design file imports this package.
package brl_pkg;

    localparam int COORD_W     = 6;
    localparam int TILE_SIZE_D = 64;
    localparam int ERR_W       = COORD_W + 2;
    localparam int QUEUE_DEPTH = 2;

    typedef logic [COORD_W-1:0]       coord_t;
    typedef logic signed [ERR_W-1:0]  err_t;

    // One line command, as accepted on the input channel.
    typedef struct packed {
        coord_t start_x;
        coord_t start_y;
        coord_t end_x;
        coord_t end_y;
    } cmd_t;

    // One plotted pixel, as delivered on the output channel.
    typedef struct packed {
        coord_t pixel_x;
        coord_t pixel_y;
        logic   last_pixel;
    } pix_t;

    // Classified line, ready for the stepper.
    typedef struct packed {
        logic   steep;
        coord_t maj0;
        coord_t min0;
        coord_t maj1;
        coord_t dmaj;
        coord_t dmin;
        logic   step_neg;
        err_t   err0;
    } job_t;

endpackage

@@ design/brl_front.sv @@
// Front end: clamps a line command and classifies it into a stepper job.
// Depends on brl_pkg.
module brl_front
    import brl_pkg::*;
#(
    parameter int TILE_SIZE = TILE_SIZE_D
)(
    input  cmd_t cmd,
    output job_t job
);

    localparam coord_t MAX_C = COORD_W'(TILE_SIZE - 1);

    coord_t ax, ay, bx, by;
    coord_t adx, ady;
    coord_t p_maj, p_min, q_maj, q_min;
    coord_t maj0, min0, maj1, min1;
    logic   steep;

    always_comb
    begin
        // Saturate coordinates that fall outside the tile.
        ax = (cmd.start_x > MAX_C) ? MAX_C : cmd.start_x;
        ay = (cmd.start_y > MAX_C) ? MAX_C : cmd.start_y;
        bx = (cmd.end_x   > MAX_C) ? MAX_C : cmd.end_x;
        by = (cmd.end_y   > MAX_C) ? MAX_C : cmd.end_y;

        adx   = (ax > bx) ? (ax - bx) : (bx - ax);
        ady   = (ay > by) ? (ay - by) : (by - ay);
        steep = ady > adx;

        p_maj = steep ? ay : ax;
        p_min = steep ? ax : ay;
        q_maj = steep ? by : bx;
        q_min = steep ? bx : by;

        // Order endpoints so the major coordinate runs upward.
        if (p_maj > q_maj)
        begin
            maj0 = q_maj; min0 = q_min; maj1 = p_maj; min1 = p_min;
        end
        else
        begin
            maj0 = p_maj; min0 = p_min; maj1 = q_maj; min1 = q_min;
        end

        job.steep    = steep;
        job.maj0     = maj0;
        job.min0     = min0;
        job.maj1     = maj1;
        job.dmaj     = maj1 - maj0;
        job.dmin     = (min1 > min0) ? (min1 - min0) : (min0 - min1);
        job.step_neg = !(min1 > min0);
        job.err0     = $signed({2'b00, (maj1 - maj0) >> 1});
    end

endmodule

@@ design/brl_queue.sv @@
// Short job queue that decouples the classifier from the stepper.
// Depends on brl_pkg.
module brl_queue
    import brl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  job_t push_data,
    output logic pop_valid,
    input  logic pop_ready,
    output job_t pop_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t             mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = count_reg != CNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

@@ design/brl_back.sv @@
// Back end: steps one job along its major axis, one pixel per cycle while
// the output is not stalled, into an output register. Depends on brl_pkg.
module brl_back
    import brl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic job_valid,
    output logic job_ready,
    input  job_t job,
    output logic pix_valid,
    input  logic pix_ready,
    output pix_t pix
);

    logic   busy_reg, busy_next;
    logic   out_valid_reg, out_valid_next;
    pix_t   out_reg, out_next;
    job_t   job_reg, job_next;
    coord_t maj_reg, maj_next;
    coord_t min_reg, min_next;
    err_t   err_reg, err_next;
    err_t   err_sub;
    logic   can_emit, at_end;

    assign can_emit  = !out_valid_reg || pix_ready;
    assign job_ready = !busy_reg;
    assign at_end    = maj_reg == job_reg.maj1;
    assign err_sub   = err_reg - $signed({2'b00, job_reg.dmin});

    always_comb
    begin
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        job_next       = job_reg;
        maj_next       = maj_reg;
        min_next       = min_reg;
        err_next       = err_reg;

        if (!busy_reg)
        begin
            // Load the next job from the queue.
            if (job_valid)
            begin
                busy_next = 1'b1;
                job_next  = job;
                maj_next  = job.maj0;
                min_next  = job.min0;
                err_next  = job.err0;
            end
            if (pix_ready)
                out_valid_next = 1'b0;
        end
        else if (can_emit)
        begin
            out_valid_next      = 1'b1;
            out_next.pixel_x    = job_reg.steep ? min_reg : maj_reg;
            out_next.pixel_y    = job_reg.steep ? maj_reg : min_reg;
            out_next.last_pixel = at_end;
            if (at_end)
                busy_next = 1'b0;
            else
            begin
                maj_next = maj_reg + 1'b1;
                if (err_sub < 0)
                begin
                    min_next = job_reg.step_neg ? min_reg - 1'b1 : min_reg + 1'b1;
                    err_next = err_sub + $signed({2'b00, job_reg.dmaj});
                end
                else
                    err_next = err_sub;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        job_reg <= job_next;
        maj_reg <= maj_next;
        min_reg <= min_next;
        err_reg <= err_next;
    end

    assign pix_valid = out_valid_reg;
    assign pix       = out_reg;

endmodule

@@ design/bresenham_line_rasterizer_unit.sv @@
// Top level of the Bresenham line rasterizer for one square tile.
// Depends on brl_pkg, brl_front, brl_queue and brl_back.
//
//   channel   dir   handshake               payload
//   cmd       in    cmd_valid / cmd_ready   cmd_t: start_x, start_y, end_x, end_y
//   pix       out   pix_valid / pix_ready   pix_t: pixel_x, pixel_y, last_pixel
//
// A command yields (major difference + 1) pixels, 1 to TILE_SIZE, one per cycle
// from the stepper in brl_back while pix is not stalled; the stepper loads each
// job while idle, before its first pixel. Commands are classified in the cycle
// they arrive and wait in a two-entry queue, so cmd_ready stays high while the
// stepper still works on earlier lines, until the queue holds two of them.
// Reset (rst_n low, asynchronous) empties the queue and the output register.
// A stall on pix holds the current pixel and freezes the stepper.
module bresenham_line_rasterizer_unit
    import brl_pkg::*;
#(
    parameter int TILE_SIZE = TILE_SIZE_D
)(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_ready,
    input  cmd_t cmd,
    output logic pix_valid,
    input  logic pix_ready,
    output pix_t pix
);

    // Classified job straight out of the front end.
    job_t front_job;
    // Queue head as seen by the stepper.
    job_t head_job;
    logic head_valid;
    logic head_ready;

    // Clamp, pick the major axis, order endpoints, set up the error term.
    brl_front #(
        .TILE_SIZE (TILE_SIZE)
    ) u_front (
        .cmd (cmd),
        .job (front_job)
    );

    // Hold classified jobs until the stepper is free.
    brl_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (cmd_valid),
        .push_ready (cmd_ready),
        .push_data  (front_job),
        .pop_valid  (head_valid),
        .pop_ready  (head_ready),
        .pop_data   (head_job)
    );

    // Advance along the major axis and emit one pixel per cycle unless pix stalls.
    brl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (head_valid),
        .job_ready (head_ready),
        .job       (head_job),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix)
    );

    // Every emitted pixel lies inside the tile.
    assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid |-> (pix.pixel_x <= COORD_W'(TILE_SIZE - 1)) &&
                      (pix.pixel_y <= COORD_W'(TILE_SIZE - 1)))
        else $error("pixel outside tile");

    // A taken pixel that is not the last is followed at once by the next one.
    assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && pix_ready && !pix.last_pixel |=> pix_valid)
        else $error("gap inside a line run");

    // The stepper only loads a job while it is idle and no pixel of a run is open.
    assert property (@(posedge clk) disable iff (!rst_n)
        head_valid && head_ready && pix_valid |-> pix.last_pixel)
        else $error("job loaded in the middle of a run");

endmodule
